@@ hw/rtl/file_transfer_packet_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// file transfer packet receiver assertion macros
// shorthand for clocked implications with reset disable
// ----------------------------------------------------------------------------
`ifndef FILE_TRANSFER_PACKET_RECEIVER_ASSERT_SVH
`define FILE_TRANSFER_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication
`define FTPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftpr assertion failed");

// next-cycle implication
`define FTPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftpr assertion failed");

`endif

@@ hw/rtl/ftpr_pkg.sv @@
// ----------------------------------------------------------------------------
// ftpr_pkg
// shared types and constants of the file transfer packet receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftpr_pkg;

    localparam int SIZE_BYTES_MAX = 4;
    localparam int NAME_BYTES_MAX = 256;
    localparam int NAME_AW        = $clog2(NAME_BYTES_MAX);
    localparam int POS_W          = 9;
    localparam int LEN_W          = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int PADDR_W        = 5;

    // register indexes
    localparam logic [2:0] REG_CODE_DATA  = 3'd0;
    localparam logic [2:0] REG_CODE_START = 3'd1;
    localparam logic [2:0] REG_CODE_END   = 3'd2;
    localparam logic [2:0] REG_TYPE_SIZE  = 3'd3;
    localparam logic [2:0] REG_TYPE_NAME  = 3'd4;

    // event kinds
    localparam logic [2:0] EVK_NAME     = 3'd0;
    localparam logic [2:0] EVK_START    = 3'd1;
    localparam logic [2:0] EVK_PAYLOAD  = 3'd2;
    localparam logic [2:0] EVK_COMPLETE = 3'd3;
    localparam logic [2:0] EVK_ERROR    = 3'd4;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_START     = 4'd1;
    localparam logic [3:0] ERR_SIZE_TYPE = 4'd2;
    localparam logic [3:0] ERR_SIZE_LONG = 4'd3;
    localparam logic [3:0] ERR_NAME_TYPE = 4'd4;
    localparam logic [3:0] ERR_SEQUENCE  = 4'd5;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd6;
    localparam logic [3:0] ERR_BAD_CODE  = 4'd7;
    localparam logic [3:0] ERR_MISMATCH  = 4'd8;
    localparam logic [3:0] ERR_TRUNCATED = 4'd9;

    typedef enum logic [2:0] {
        PH_START,
        PH_IDLE,
        PH_DATA,
        PH_END,
        PH_SKIP,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic [7:0] code_data;
        logic [7:0] code_start;
        logic [7:0] code_end;
        logic [7:0] type_size;
        logic [7:0] type_name;
    } cfg_t;

    // queue entry: a finished event, or a name compare resolved in the back
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         value;
        logic [31:0]        offset;
        logic [31:0]        fsize;
        logic [3:0]         err;
        logic               cmp;
        logic               cmp_last;
        logic [NAME_AW-1:0] addr;
    } qent_t;

endpackage

`default_nettype wire

@@ hw/rtl/ftpr_if.sv @@
// ----------------------------------------------------------------------------
// ftpr stream interfaces
// valid/ready channels for packet bytes and receiver events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ftpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_end;

    modport source (output valid, output rx_byte, output packet_end, input ready);
    modport sink (input valid, input rx_byte, input packet_end, output ready);
endinterface

interface ftpr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  byte_value;
    logic [31:0] byte_offset;
    logic [31:0] file_size;
    logic [3:0]  error_code;

    modport source (output valid, output event_kind, output byte_value,
                    output byte_offset, output file_size, output error_code,
                    input ready);
    modport sink (input valid, input event_kind, input byte_value,
                  input byte_offset, input file_size, input error_code,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ftpr_ram.sv @@
// ----------------------------------------------------------------------------
// ftpr_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ftpr_front.sv @@
// ----------------------------------------------------------------------------
// ftpr_front
// packet parser: classifies each byte and queues the resulting event
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftpr_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic                        packet_end,
    input  wire ftpr_pkg::cfg_t              cfg,
    output logic                             push,
    output ftpr_pkg::qent_t                  push_ent,
    output logic                             name_we,
    output logic [ftpr_pkg::NAME_AW-1:0]     name_waddr
);

    localparam int PW = ftpr_pkg::POS_W;

    ftpr_pkg::phase_t                phase_reg, phase_next;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic [31:0]                     acc_reg, acc_next;
    logic [31:0]                     dsize_reg, dsize_next;
    logic [ftpr_pkg::LEN_W-1:0]      slen_reg, slen_next;
    logic [7:0]                      nlen_reg, nlen_next;
    logic [7:0]                      seq_reg, seq_next;
    logic [31:0]                     rcnt_reg, rcnt_next;
    logic [15:0]                     drem_reg, drem_next;

    logic [3:0]                      err;
    logic                            complete;
    logic                            active;
    logic [PW-1:0]                   l_pos3, l_pos4;
    logic [7:0]                      name_idx;
    logic [1:0]                      size_k;
    logic [15:0]                     drem_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ftpr_pkg::PH_START;
            pos_reg   <= '0;
            acc_reg   <= '0;
            dsize_reg <= '0;
            slen_reg  <= '0;
            nlen_reg  <= '0;
            seq_reg   <= '0;
            rcnt_reg  <= '0;
            drem_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            dsize_reg <= dsize_next;
            slen_reg  <= slen_next;
            nlen_reg  <= nlen_next;
            seq_reg   <= seq_next;
            rcnt_reg  <= rcnt_next;
            drem_reg  <= drem_next;
        end
    end

    assign l_pos3   = PW'(slen_reg) + PW'(3);
    assign l_pos4   = PW'(slen_reg) + PW'(4);
    assign name_idx = 8'(pos_reg - PW'(5) - PW'(slen_reg));
    assign size_k   = 2'(pos_reg - PW'(3));
    assign drem_cur = {drem_reg[15:8], rx_byte};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        dsize_next = dsize_reg;
        slen_next  = slen_reg;
        nlen_next  = nlen_reg;
        seq_next   = seq_reg;
        rcnt_next  = rcnt_reg;
        drem_next  = drem_reg;
        err        = ftpr_pkg::ERR_NONE;
        complete   = 1'b0;
        active     = 1'b0;
        push       = 1'b0;
        name_we    = 1'b0;
        name_waddr = ftpr_pkg::NAME_AW'(name_idx);
        push_ent   = '0;
        push_ent.fsize  = dsize_reg;
        push_ent.value  = rx_byte;
        push_ent.offset = rcnt_reg;
        push_ent.addr   = ftpr_pkg::NAME_AW'(name_idx);

        if (accept)
        begin
            unique case (phase_reg)
                ftpr_pkg::PH_START:
                begin
                    active = 1'b1;
                    if (pos_reg == PW'(0))
                    begin
                        if (rx_byte != cfg.code_start) err = ftpr_pkg::ERR_START;
                    end
                    else if (pos_reg == PW'(1))
                    begin
                        if (rx_byte != cfg.type_size) err = ftpr_pkg::ERR_SIZE_TYPE;
                    end
                    else if (pos_reg == PW'(2))
                    begin
                        if (rx_byte > 8'(ftpr_pkg::SIZE_BYTES_MAX))
                        begin
                            err = ftpr_pkg::ERR_SIZE_LONG;
                        end
                        else
                        begin
                            slen_next = ftpr_pkg::LEN_W'(rx_byte);
                            acc_next  = '0;
                        end
                    end
                    else if (pos_reg < l_pos3)
                    begin
                        acc_next = acc_reg | ({24'd0, rx_byte} << {size_k, 3'd0});
                    end
                    else if (pos_reg == l_pos3)
                    begin
                        if (rx_byte != cfg.type_name) err = ftpr_pkg::ERR_NAME_TYPE;
                        else dsize_next = acc_reg;
                    end
                    else if (pos_reg == l_pos4)
                    begin
                        nlen_next      = rx_byte;
                        rcnt_next      = '0;
                        push           = 1'b1;
                        push_ent.kind  = ftpr_pkg::EVK_START;
                        push_ent.value = '0;
                        push_ent.offset = '0;
                        complete       = (rx_byte == 8'd0);
                    end
                    else
                    begin
                        name_we         = 1'b1;
                        push            = 1'b1;
                        push_ent.kind   = ftpr_pkg::EVK_NAME;
                        push_ent.offset = {24'd0, name_idx};
                        complete        = (9'(name_idx) + 9'd1 == 9'(nlen_reg));
                    end
                    pos_next = pos_reg + PW'(1);
                    if (err == ftpr_pkg::ERR_NONE && complete)
                    begin
                        phase_next = packet_end ? ftpr_pkg::PH_IDLE : ftpr_pkg::PH_SKIP;
                        pos_next   = '0;
                    end
                end
                ftpr_pkg::PH_IDLE:
                begin
                    active = 1'b1;
                    if (rx_byte == cfg.code_data)
                    begin
                        phase_next = ftpr_pkg::PH_DATA;
                    end
                    else if (rx_byte == cfg.code_end)
                    begin
                        phase_next = ftpr_pkg::PH_END;
                        acc_next   = '0;
                    end
                    else
                    begin
                        err = ftpr_pkg::ERR_BAD_CODE;
                    end
                    pos_next = PW'(1);
                end
                ftpr_pkg::PH_DATA:
                begin
                    active = 1'b1;
                    if (pos_reg == PW'(1))
                    begin
                        if (rx_byte != seq_reg) err = ftpr_pkg::ERR_SEQUENCE;
                    end
                    else if (pos_reg == PW'(2))
                    begin
                        drem_next = {rx_byte, 8'd0};
                    end
                    else if (pos_reg == PW'(3))
                    begin
                        drem_next = drem_cur;
                        complete  = (drem_cur == 16'd0);
                    end
                    else if (rcnt_reg >= dsize_reg)
                    begin
                        err = ftpr_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        push          = 1'b1;
                        push_ent.kind = ftpr_pkg::EVK_PAYLOAD;
                        rcnt_next     = rcnt_reg + 32'd1;
                        drem_next     = drem_reg - 16'd1;
                        complete      = (drem_reg == 16'd1);
                    end
                    if (pos_reg < PW'(4)) pos_next = pos_reg + PW'(1);
                    if (err == ftpr_pkg::ERR_NONE && complete)
                    begin
                        seq_next   = seq_reg + 8'd1;
                        phase_next = packet_end ? ftpr_pkg::PH_IDLE : ftpr_pkg::PH_SKIP;
                        pos_next   = '0;
                    end
                end
                ftpr_pkg::PH_END:
                begin
                    active = 1'b1;
                    if (pos_reg == PW'(1))
                    begin
                        if (rx_byte != cfg.type_size) err = ftpr_pkg::ERR_MISMATCH;
                    end
                    else if (pos_reg == PW'(2))
                    begin
                        if (rx_byte != 8'(slen_reg)) err = ftpr_pkg::ERR_MISMATCH;
                    end
                    else if (pos_reg < l_pos3)
                    begin
                        acc_next = acc_reg | ({24'd0, rx_byte} << {size_k, 3'd0});
                    end
                    else if (pos_reg == l_pos3)
                    begin
                        if (acc_reg != dsize_reg || rx_byte != cfg.type_name)
                            err = ftpr_pkg::ERR_MISMATCH;
                    end
                    else if (pos_reg == l_pos4)
                    begin
                        if (rx_byte != nlen_reg)
                        begin
                            err = ftpr_pkg::ERR_MISMATCH;
                        end
                        else if (rx_byte == 8'd0)
                        begin
                            // empty name: nothing to compare
                            complete       = 1'b1;
                            push           = 1'b1;
                            push_ent.kind  = ftpr_pkg::EVK_COMPLETE;
                            push_ent.value = '0;
                        end
                    end
                    else
                    begin
                        // name compare finished in the back against the store
                        push              = 1'b1;
                        push_ent.cmp      = 1'b1;
                        complete          = (9'(name_idx) + 9'd1 == 9'(nlen_reg));
                        push_ent.cmp_last = complete;
                    end
                    pos_next = pos_reg + PW'(1);
                    if (err == ftpr_pkg::ERR_NONE && complete)
                    begin
                        phase_next = ftpr_pkg::PH_DONE;
                    end
                end
                ftpr_pkg::PH_SKIP:
                begin
                    if (packet_end)
                    begin
                        phase_next = ftpr_pkg::PH_IDLE;
                        pos_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase

            if (active && err == ftpr_pkg::ERR_NONE && !complete && packet_end)
            begin
                err = ftpr_pkg::ERR_TRUNCATED;
            end
            if (err != ftpr_pkg::ERR_NONE)
            begin
                push       = 1'b1;
                push_ent   = '0;
                push_ent.kind = ftpr_pkg::EVK_ERROR;
                push_ent.err  = err;
                name_we    = 1'b0;
                phase_next = ftpr_pkg::PH_FAIL;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ftpr_fifo.sv @@
// ----------------------------------------------------------------------------
// ftpr_fifo
// short event queue between parser and output side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftpr_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ftpr_pkg::qent_t push_ent,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output ftpr_pkg::qent_t      head
);

    localparam int AW = ftpr_pkg::FIFO_AW;

    ftpr_pkg::qent_t  slot_reg [ftpr_pkg::FIFO_DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == (AW+1)'(ftpr_pkg::FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push) wptr_reg <= wptr_reg + AW'(1);
            if (do_pop) rptr_reg <= rptr_reg + AW'(1);
            if (do_push && !do_pop) cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_ent;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ftpr_back.sv @@
// ----------------------------------------------------------------------------
// ftpr_back
// drains the queue, resolves name compares, holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftpr_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire ftpr_pkg::qent_t         head,
    output logic                         pop,
    output logic                         name_re,
    output logic [ftpr_pkg::NAME_AW-1:0] name_raddr,
    input  wire logic [7:0]              name_rdata,
    ftpr_out_if.source                   evt
);

    ftpr_pkg::qent_t a_reg;
    logic            a_valid_reg;
    logic            mm_reg, mm_next;
    logic            o_valid_reg;
    ftpr_pkg::qent_t o_reg, o_next;
    logic            produce;
    logic            advance;
    logic            mm_now;

    assign advance    = !o_valid_reg || evt.ready;
    assign pop        = advance && head_valid;
    assign name_re    = advance;
    assign name_raddr = head.addr;

    always_comb
    begin
        mm_now  = mm_reg || (name_rdata != a_reg.value);
        mm_next = mm_reg;
        o_next  = a_reg;
        produce = 1'b1;
        if (a_reg.cmp)
        begin
            mm_next = mm_now;
            produce = a_reg.cmp_last;
            o_next  = '0;
            if (mm_now)
            begin
                o_next.kind = ftpr_pkg::EVK_ERROR;
                o_next.err  = ftpr_pkg::ERR_MISMATCH;
            end
            else
            begin
                o_next.kind   = ftpr_pkg::EVK_COMPLETE;
                o_next.offset = a_reg.offset;
                o_next.fsize  = a_reg.fsize;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            mm_reg      <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= head_valid;
            o_valid_reg <= a_valid_reg && produce;
            if (a_valid_reg) mm_reg <= mm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= head;
            o_reg <= o_next;
        end
    end

    assign evt.valid       = o_valid_reg;
    assign evt.event_kind  = o_reg.kind;
    assign evt.byte_value  = o_reg.value;
    assign evt.byte_offset = o_reg.offset;
    assign evt.file_size   = o_reg.fsize;
    assign evt.error_code  = o_reg.err;

endmodule

`default_nettype wire

@@ hw/rtl/file_transfer_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// file_transfer_packet_receiver
// receive side of a length/type/value file transfer over link-layer packets
// ----------------------------------------------------------------------------
// takes one packet byte per cycle on rx, sustained, and reports name bytes,
// start accepted, payload bytes with their file offset, completion or one
// error on evt, registered in the queue, then in a_reg and then in o_reg;
// the parser feeds a four-entry event queue, and the output side
// reads the 256-byte name store (one read port, registered) to check the end
// packet's name, so rx only stalls when the queue fills under evt back
// pressure; the name store needs no clearing pass after reset; after an
// error or completion all bytes are swallowed until reset; configuration
// registers (control codes and type bytes) sit on an apb-style port at byte
// addresses 0 to 16 and should only be written while the block is idle
`timescale 1ns / 1ps
`default_nettype none

module file_transfer_packet_receiver (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ftpr_in_if.sink                           rx,
    ftpr_out_if.source                        evt,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ftpr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    ftpr_pkg::cfg_t                cfg_reg;
    logic [2:0]                    reg_idx;
    logic                          cfg_wr;
    logic [7:0]                    rd_byte;

    logic                          accept;
    logic                          push;
    ftpr_pkg::qent_t               push_ent;
    logic                          full;
    logic                          head_valid;
    ftpr_pkg::qent_t               head;
    logic                          pop;
    logic                          name_we;
    logic [ftpr_pkg::NAME_AW-1:0]  name_waddr;
    logic                          name_re;
    logic [ftpr_pkg::NAME_AW-1:0]  name_raddr;
    logic [7:0]                    name_rdata;

    // configuration port, zero wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_data  <= 8'd1;
            cfg_reg.code_start <= 8'd2;
            cfg_reg.code_end   <= 8'd3;
            cfg_reg.type_size  <= 8'd0;
            cfg_reg.type_name  <= 8'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ftpr_pkg::REG_CODE_DATA:  cfg_reg.code_data  <= pwdata[7:0];
                ftpr_pkg::REG_CODE_START: cfg_reg.code_start <= pwdata[7:0];
                ftpr_pkg::REG_CODE_END:   cfg_reg.code_end   <= pwdata[7:0];
                ftpr_pkg::REG_TYPE_SIZE:  cfg_reg.type_size  <= pwdata[7:0];
                ftpr_pkg::REG_TYPE_NAME:  cfg_reg.type_name  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ftpr_pkg::REG_CODE_DATA:  rd_byte = cfg_reg.code_data;
            ftpr_pkg::REG_CODE_START: rd_byte = cfg_reg.code_start;
            ftpr_pkg::REG_CODE_END:   rd_byte = cfg_reg.code_end;
            ftpr_pkg::REG_TYPE_SIZE:  rd_byte = cfg_reg.type_size;
            ftpr_pkg::REG_TYPE_NAME:  rd_byte = cfg_reg.type_name;
            default:                  rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

    // rx takes a transfer whenever the queue has room
    assign rx.ready = !full;
    assign accept   = rx.valid && !full;

    // front: parser and name store writes
    ftpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx.rx_byte),
        .packet_end (rx.packet_end),
        .cfg        (cfg_reg),
        .push       (push),
        .push_ent   (push_ent),
        .name_we    (name_we),
        .name_waddr (name_waddr)
    );

    // event queue
    ftpr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ent   (push_ent),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    // name store, written at the start packet, read back at the end packet
    ftpr_ram #(
        .WIDTH (8),
        .DEPTH (ftpr_pkg::NAME_BYTES_MAX)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (rx.rx_byte),
        .re    (name_re),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    // back: compare resolution and output register
    ftpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .name_re    (name_re),
        .name_raddr (name_raddr),
        .name_rdata (name_rdata),
        .evt        (evt)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ftpr_checker.sv @@
// ----------------------------------------------------------------------------
// ftpr_checker
// port-level checks of the file transfer packet receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "file_transfer_packet_receiver_assert.svh"

module ftpr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  event_kind,
    input wire logic [7:0]  byte_value,
    input wire logic [31:0] byte_offset,
    input wire logic [31:0] file_size,
    input wire logic [3:0]  error_code
);

    `FTPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(event_kind) && $stable(byte_offset))
    `FTPR_ASSERT_NOW(a_err_form, out_valid && event_kind == ftpr_pkg::EVK_ERROR,
        error_code != ftpr_pkg::ERR_NONE && file_size == 32'd0 && byte_value == 8'd0)
    `FTPR_ASSERT_NOW(a_ok_form, out_valid && event_kind != ftpr_pkg::EVK_ERROR,
        error_code == ftpr_pkg::ERR_NONE)
    `FTPR_ASSERT_NEXT(a_after_err, out_valid && out_ready && event_kind == ftpr_pkg::EVK_ERROR,
        !out_valid || event_kind == ftpr_pkg::EVK_ERROR)

endmodule

bind file_transfer_packet_receiver ftpr_checker u_ftpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (evt.valid),
    .out_ready   (evt.ready),
    .event_kind  (evt.event_kind),
    .byte_value  (evt.byte_value),
    .byte_offset (evt.byte_offset),
    .file_size   (evt.file_size),
    .error_code  (evt.error_code)
);

`default_nettype wire

@@ test/tb_file_transfer_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_file_transfer_packet_receiver
// self-checking bench: one file transfer session per run, with random ending
// ----------------------------------------------------------------------------
// a start packet, a stream of data packets and an end packet are fed through
// the rx channel with random gaps; a predictor tracks the receiver state and
// queues the expected events, which the evt monitor compares field by field;
// the block latches failure or completion until reset, so each run ends the
// session one way, chosen at random: clean completion, overflow, end name
// mismatch, truncated packet, bad control code or wrong sequence number
`timescale 1ns / 1ps

module tb_file_transfer_packet_receiver;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] offset;
        logic [31:0] fsize;
        logic [3:0]  err;
    } evt_rec_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } rx_item_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ftpr_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ftpr_in_if  rx_if ();
    ftpr_out_if evt_if ();

    file_transfer_packet_receiver DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .evt     (evt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // predictor state of the receiver
    // ------------------------------------------------------------------------
    ftpr_pkg::cfg_t   cfg;
    ftpr_pkg::phase_t rcv_phase;
    int          rcv_pos;
    logic [31:0] size_acc;
    logic [31:0] size_decl;
    logic [7:0]  size_len;
    logic [7:0]  name_len;
    logic [7:0]  name_mem [ftpr_pkg::NAME_BYTES_MAX];
    logic [7:0]  seq_expected;
    logic [31:0] payload_count;
    logic [15:0] payload_left;
    logic        name_differs;

    evt_rec_t expected_events [$];
    rx_item_t pending_bytes [$];

    int failures;
    int bytes_taken;
    int events_seen;
    int payload_seen;
    int name_seen;
    int cycles;
    bit rx_taken;

    // mirror of one receiver step, queues the event it causes, if any
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [3:0] err;
        bit         complete;
        bit         emit;
        int         pos;
        int         len;
        int         i;
        evt_rec_t   e;
        err      = ftpr_pkg::ERR_NONE;
        complete = 0;
        emit     = 0;
        pos      = rcv_pos;
        len      = size_len;
        e        = '0;
        case (rcv_phase)
            ftpr_pkg::PH_START:
            begin
                if (pos == 0)
                begin
                    if (b != cfg.code_start) err = ftpr_pkg::ERR_START;
                end
                else if (pos == 1)
                begin
                    if (b != cfg.type_size) err = ftpr_pkg::ERR_SIZE_TYPE;
                end
                else if (pos == 2)
                begin
                    if (b > ftpr_pkg::SIZE_BYTES_MAX) err = ftpr_pkg::ERR_SIZE_LONG;
                    else
                    begin
                        size_len = b;
                        size_acc = '0;
                    end
                end
                else if (pos < 3 + len)
                begin
                    if (pos - 3 < 4) size_acc |= 32'(b) << (8 * (pos - 3));
                end
                else if (pos == 3 + len)
                begin
                    if (b != cfg.type_name) err = ftpr_pkg::ERR_NAME_TYPE;
                    else size_decl = size_acc;
                end
                else if (pos == 4 + len)
                begin
                    name_len      = b;
                    payload_count = '0;
                    e.kind        = ftpr_pkg::EVK_START;
                    e.fsize       = size_decl;
                    emit          = 1;
                    if (b == 0) complete = 1;
                end
                else
                begin
                    i = pos - 5 - len;
                    if (i < ftpr_pkg::NAME_BYTES_MAX) name_mem[i] = b;
                    e.kind   = ftpr_pkg::EVK_NAME;
                    e.value  = b;
                    e.offset = i;
                    e.fsize  = size_decl;
                    emit     = 1;
                    if (i + 1 == name_len) complete = 1;
                end
                rcv_pos = pos + 1;
                if (err == ftpr_pkg::ERR_NONE && complete)
                begin
                    rcv_phase = last ? ftpr_pkg::PH_IDLE : ftpr_pkg::PH_SKIP;
                    rcv_pos   = 0;
                end
            end
            ftpr_pkg::PH_IDLE:
            begin
                // data code wins over end code when both match
                if (b == cfg.code_data) rcv_phase = ftpr_pkg::PH_DATA;
                else if (b == cfg.code_end)
                begin
                    rcv_phase    = ftpr_pkg::PH_END;
                    size_acc     = '0;
                    name_differs = 1'b0;
                end
                else err = ftpr_pkg::ERR_BAD_CODE;
                rcv_pos = 1;
            end
            ftpr_pkg::PH_DATA:
            begin
                if (pos == 1)
                begin
                    if (b != seq_expected) err = ftpr_pkg::ERR_SEQUENCE;
                end
                else if (pos == 2) payload_left = {b, 8'h00};
                else if (pos == 3)
                begin
                    payload_left = payload_left | 16'(b);
                    if (payload_left == 0) complete = 1;
                end
                else if (payload_count >= size_decl) err = ftpr_pkg::ERR_OVERFLOW;
                else
                begin
                    e.kind   = ftpr_pkg::EVK_PAYLOAD;
                    e.value  = b;
                    e.offset = payload_count;
                    e.fsize  = size_decl;
                    emit     = 1;
                    payload_count++;
                    payload_left--;
                    if (payload_left == 0) complete = 1;
                end
                if (pos < 4) rcv_pos = pos + 1;
                if (err == ftpr_pkg::ERR_NONE && complete)
                begin
                    seq_expected++;
                    rcv_phase = last ? ftpr_pkg::PH_IDLE : ftpr_pkg::PH_SKIP;
                    rcv_pos   = 0;
                end
            end
            ftpr_pkg::PH_END:
            begin
                if (pos == 1)
                begin
                    if (b != cfg.type_size) err = ftpr_pkg::ERR_MISMATCH;
                end
                else if (pos == 2)
                begin
                    if (b != size_len) err = ftpr_pkg::ERR_MISMATCH;
                end
                else if (pos < 3 + len)
                begin
                    if (pos - 3 < 4) size_acc |= 32'(b) << (8 * (pos - 3));
                end
                else if (pos == 3 + len)
                begin
                    if (size_acc != size_decl || b != cfg.type_name)
                        err = ftpr_pkg::ERR_MISMATCH;
                end
                else if (pos == 4 + len)
                begin
                    if (b != name_len) err = ftpr_pkg::ERR_MISMATCH;
                    else if (b == 0) complete = 1;
                end
                else
                begin
                    i = pos - 5 - len;
                    if (i < ftpr_pkg::NAME_BYTES_MAX && name_mem[i] != b) name_differs = 1'b1;
                    if (i + 1 == name_len) complete = 1;
                end
                rcv_pos = pos + 1;
                if (err == ftpr_pkg::ERR_NONE && complete)
                begin
                    if (name_differs) err = ftpr_pkg::ERR_MISMATCH;
                    else
                    begin
                        e.kind   = ftpr_pkg::EVK_COMPLETE;
                        e.offset = payload_count;
                        e.fsize  = size_decl;
                        emit     = 1;
                        rcv_phase = ftpr_pkg::PH_DONE;
                    end
                end
            end
            ftpr_pkg::PH_SKIP:
            begin
                // trailing bytes, swallowed up to the packet end
                if (last)
                begin
                    rcv_phase = ftpr_pkg::PH_IDLE;
                    rcv_pos   = 0;
                end
                return;
            end
            default: return;
        endcase
        // packet end before the last field
        if (err == ftpr_pkg::ERR_NONE && !complete && last) err = ftpr_pkg::ERR_TRUNCATED;
        if (err != ftpr_pkg::ERR_NONE)
        begin
            // an error replaces whatever event this byte would have caused
            e       = '0;
            e.kind  = ftpr_pkg::EVK_ERROR;
            e.err   = err;
            expected_events.push_back(e);
            rcv_phase = ftpr_pkg::PH_FAIL;
        end
        else if (emit) expected_events.push_back(e);
    endtask

    // ------------------------------------------------------------------------
    // rx driver: inputs change at the falling edge
    // ------------------------------------------------------------------------
    int gap_left;
    bit no_gaps;

    always @(posedge clk)
    begin
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            track_byte(rx_if.rx_byte, rx_if.packet_end);
            bytes_taken++;
            rx_taken = 1;
        end
    end

    always @(negedge clk)
    begin
        if (rx_taken)
        begin
            rx_taken = 0;
            void'(pending_bytes.pop_front());
            // mostly no gap, some short gaps, a few long, and quiet stretches with none
            if ($urandom_range(0, 149) == 0) no_gaps = !no_gaps;
            if (no_gaps) gap_left = 0;
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:  gap_left = $urandom_range(1, 3);
                    5:              gap_left = $urandom_range(10, 30);
                    default:        gap_left = 0;
                endcase
            end
        end
        if (gap_left > 0)
        begin
            gap_left--;
            rx_if.valid = 1'b0;
        end
        else if (pending_bytes.size() > 0)
        begin
            rx_if.valid      = 1'b1;
            rx_if.rx_byte    = pending_bytes[0].b;
            rx_if.packet_end = pending_bytes[0].last;
        end
        else rx_if.valid = 1'b0;
    end

    // ------------------------------------------------------------------------
    // evt monitor: sampled at the rising edge, ready changes at the falling
    // ------------------------------------------------------------------------
    int  hold_left;
    bit  hold_done;
    int  stall_left;
    evt_rec_t want;

    // one long hold-off so the event queue fills and rx stalls
    always @(posedge clk)
    begin
        if (!hold_done && bytes_taken >= 200)
        begin
            hold_left <= 300;
            hold_done <= 1;
        end
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0) evt_if.ready = 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            evt_if.ready = 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: stall_left = $urandom_range(1, 3);
                4:          stall_left = $urandom_range(10, 30);
                default:    stall_left = 0;
            endcase
            evt_if.ready = (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && evt_if.valid && evt_if.ready)
        begin
            events_seen++;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event kind %0d", evt_if.event_kind);
                failures++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_if.event_kind == ftpr_pkg::EVK_PAYLOAD) payload_seen++;
                if (evt_if.event_kind == ftpr_pkg::EVK_NAME) name_seen++;
                if (evt_if.event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind,
                           evt_if.event_kind);
                    failures++;
                end
                if (evt_if.byte_value !== want.value)
                begin
                    $error("byte_value: expected %0d, got %0d", want.value,
                           evt_if.byte_value);
                    failures++;
                end
                if (evt_if.byte_offset !== want.offset)
                begin
                    $error("byte_offset: expected %0d, got %0d", want.offset,
                           evt_if.byte_offset);
                    failures++;
                end
                if (evt_if.file_size !== want.fsize)
                begin
                    $error("file_size: expected %0d, got %0d", want.fsize,
                           evt_if.file_size);
                    failures++;
                end
                if (evt_if.error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err,
                           evt_if.error_code);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL file_transfer_packet_receiver");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    logic [7:0]  file_name [$];
    logic [31:0] file_size_tx;
    logic [7:0]  seq_tx;

    task automatic push_byte(input logic [7:0] b, input logic last);
        rx_item_t it;
        it.b    = b;
        it.last = last;
        pending_bytes.push_back(it);
    endtask

    // apb write: setup then access, predictor follows
    task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = {24'h0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            ftpr_pkg::REG_CODE_DATA:  cfg.code_data  = v;
            ftpr_pkg::REG_CODE_START: cfg.code_start = v;
            ftpr_pkg::REG_CODE_END:   cfg.code_end   = v;
            ftpr_pkg::REG_TYPE_SIZE:  cfg.type_size  = v;
            ftpr_pkg::REG_TYPE_NAME:  cfg.type_name  = v;
            default: ;
        endcase
    endtask

    // block drained: nothing queued, nothing expected, then a latency margin
    task automatic wait_drained();
        wait (pending_bytes.size() == 0 && expected_events.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    // optional trailing bytes, packet end on the last byte either way
    task automatic close_packet(input logic [7:0] b, input bit trail);
        int n;
        if (!trail) push_byte(b, 1'b1);
        else
        begin
            push_byte(b, 1'b0);
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                push_byte(8'($urandom_range(0, 255)), k == n - 1);
        end
    endtask

    task automatic send_data(input int len, input bit trail, input bit ends_short);
        logic [7:0] b;
        push_byte(cfg.code_data, 1'b0);
        push_byte(seq_tx, 1'b0);
        push_byte(len[15:8], 1'b0);
        if (len == 0) close_packet(len[7:0], trail);
        else
        begin
            push_byte(len[7:0], 1'b0);
            for (int k = 0; k < len; k++)
            begin
                case (k)
                    0: b = 8'h00;
                    1: b = 8'hff;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                if (ends_short && k == len / 2)
                begin
                    push_byte(b, 1'b1);
                    break;
                end
                if (k == len - 1) close_packet(b, trail);
                else push_byte(b, 1'b0);
            end
        end
        seq_tx++;
    endtask

    task automatic send_end(input bit corrupt);
        int flip;
        flip = $urandom_range(0, file_name.size() - 1);
        push_byte(cfg.code_end, 1'b0);
        push_byte(cfg.type_size, 1'b0);
        push_byte(8'd4, 1'b0);
        for (int k = 0; k < 4; k++) push_byte(file_size_tx[8*k +: 8], 1'b0);
        push_byte(cfg.type_name, 1'b0);
        push_byte(8'(file_name.size()), 1'b0);
        foreach (file_name[k])
            push_byte(file_name[k] ^ ((corrupt && k == flip) ? 8'h01 : 8'h00),
                      k == file_name.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int lens [$];
    int total;
    int ending;
    int name_count;

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = 8'h00;
        rx_if.packet_end = 1'b0;
        evt_if.ready     = 1'b0;
        failures = 0; bytes_taken = 0; events_seen = 0; cycles = 0;
        payload_seen = 0; name_seen = 0; rx_taken = 0; gap_left = 0;
        no_gaps = 0; hold_left = 0; hold_done = 0; stall_left = 0; seq_tx = 0;
        cfg = '{code_data: 8'd1, code_start: 8'd2, code_end: 8'd3,
                type_size: 8'd0, type_name: 8'd1};
        rcv_phase = ftpr_pkg::PH_START; rcv_pos = 0; size_acc = '0; size_decl = '0;
        size_len = '0; name_len = '0; seq_expected = '0; payload_count = '0;
        payload_left = '0; name_differs = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first setting: extremes, data and end codes equal so data wins
        reg_write(ftpr_pkg::REG_CODE_START, 8'h00);
        reg_write(ftpr_pkg::REG_TYPE_SIZE,  8'hff);
        reg_write(ftpr_pkg::REG_TYPE_NAME,  8'h00);
        reg_write(ftpr_pkg::REG_CODE_DATA,  8'hff);
        reg_write(ftpr_pkg::REG_CODE_END,   8'hff);

        ending = $urandom_range(0, 5);

        // payload plan: empty packet, short ones, one with a nonzero high length
        lens = '{0, 2, 1, 256};
        total = 259;
        while (total < 700)
        begin
            lens.push_back($urandom_range(1, 24));
            total += lens[$];
        end
        file_size_tx = (ending == 1) ? total : total + $urandom_range(0, 3);

        // start packet: four little-endian size bytes, then the name
        name_count = $urandom_range(1, 24);
        for (int k = 0; k < name_count; k++)
            file_name.push_back(8'($urandom_range(0, 255)));
        push_byte(cfg.code_start, 1'b0);
        push_byte(cfg.type_size, 1'b0);
        push_byte(8'd4, 1'b0);
        for (int k = 0; k < 4; k++) push_byte(file_size_tx[8*k +: 8], 1'b0);
        push_byte(cfg.type_name, 1'b0);
        push_byte(8'(file_name.size()), 1'b0);
        for (int k = 0; k < name_count - 1; k++) push_byte(file_name[k], 1'b0);
        close_packet(file_name[name_count - 1], 1'b1);

        foreach (lens[k])
        begin
            // change the control codes once midway through the payload
            if (k == lens.size() / 2)
            begin
                wait_drained();
                reg_write(ftpr_pkg::REG_CODE_DATA, 8'h00);
                reg_write(ftpr_pkg::REG_CODE_END,  8'h5a);
            end
            send_data(lens[k], $urandom_range(0, 9) == 0, 1'b0);
        end

        // type bytes and the start code may change before the end packet
        wait_drained();
        reg_write(ftpr_pkg::REG_TYPE_SIZE, 8'h33);
        reg_write(ftpr_pkg::REG_TYPE_NAME, 8'hff);
        reg_write(ftpr_pkg::REG_CODE_START, 8'hff);

        case (ending)
            0: send_end(1'b0);
            1: send_data(3, 1'b0, 1'b0);
            2: send_end(1'b1);
            3: send_data(8, 1'b0, 1'b1);
            4: push_byte(8'h77, 1'b1);
            default:
            begin
                seq_tx++;
                send_data(4, 1'b0, 1'b0);
            end
        endcase
        // the block is latched now: these bytes are swallowed
        for (int k = 0; k < 8; k++) push_byte(8'($urandom_range(0, 255)), k[0]);

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $error("%0d expected events never arrived", expected_events.size());
            failures++;
        end
        $display("covered %0d input bytes, %0d events (%0d name, %0d payload)",
                 bytes_taken, events_seen, name_seen, payload_seen);
        $display("session ending %0d, declared size %0d, %0d cycles",
                 ending, file_size_tx, cycles);
        if (failures == 0)
            $display("PASS file_transfer_packet_receiver");
        else
            $display("FAIL file_transfer_packet_receiver");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ftpr_pkg.sv
hw/rtl/ftpr_if.sv
hw/rtl/ftpr_ram.sv
hw/rtl/ftpr_front.sv
hw/rtl/ftpr_fifo.sv
hw/rtl/ftpr_back.sv
hw/rtl/file_transfer_packet_receiver.sv
hw/rtl/ftpr_checker.sv
test/tb_file_transfer_packet_receiver.sv
